FILE: sv/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pts_pkg.sv
// Shared types and constants of the periodic task tick scheduler.
// No dependencies; every scheduler module imports this package.
package pts_pkg;

  // Number of task slots, one per priority level (1 to 16).
  localparam int unsigned NUM_SLOTS  = 8;
  localparam int unsigned SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Field widths.
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned TASK_W      = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [SLOT_IDX_W-1:0] LAST_SLOT     = SLOT_IDX_W'(NUM_SLOTS - 1);
  localparam logic [TASK_W:0]       NUM_SLOTS_EXT = (TASK_W + 1)'(NUM_SLOTS);

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_DUE    = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_e;

  // Request types.
  typedef enum logic {
    REQ_CREATE = 1'b0,
    REQ_TICK   = 1'b1
  } req_e;

  // One result pushed from the sequencer into the output register.
  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [TASK_W-1:0] task_id;
    logic              last;
  } result_t;

  // Write request into the slot table.
  typedef struct packed {
    logic                  used_we;
    logic                  period_we;
    logic                  cd_we;
    logic [SLOT_IDX_W-1:0] idx;
    logic [TIME_W-1:0]     period;
    logic [TIME_W-1:0]     countdown;
  } tbl_wr_t;

  // Read data of the slot table.
  typedef struct packed {
    logic              used;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] countdown;
  } tbl_rd_t;

endpackage

FILE: sv/pts_slot_tbl.sv
// Slot table: period and countdown storage plus the used flags.
// Depends on pts_pkg. One read index and one write port per cycle.
module pts_slot_tbl
  import pts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [SLOT_IDX_W-1:0] rd_idx_i,
  output tbl_rd_t               rd_o,
  input  tbl_wr_t               wr_i
);

  logic [TIME_W-1:0] period_q [NUM_SLOTS];
  logic [TIME_W-1:0] cd_q     [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] used_q;

  // Used flags are control state and clear on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_i.used_we) begin
      used_q[wr_i.idx] <= 1'b1;
    end
  end

  // Period and countdown only hold meaning once the slot is used.
  always_ff @(posedge clk_i) begin
    if (wr_i.period_we) begin
      period_q[wr_i.idx] <= wr_i.period;
    end
    if (wr_i.cd_we) begin
      cd_q[wr_i.idx] <= wr_i.countdown;
    end
  end

  // Read port.
  assign rd_o.used      = used_q[rd_idx_i];
  assign rd_o.period    = period_q[rd_idx_i];
  assign rd_o.countdown = cd_q[rd_idx_i];

endmodule

FILE: sv/pts_dec_unit.sv
// Shared countdown unit: due detection and one decrementer.
// Depends on pts_pkg. Used once per slot visit during a tick walk.
module pts_dec_unit
  import pts_pkg::*;
(
  input  logic [TIME_W-1:0] countdown_i,
  input  logic [TIME_W-1:0] period_i,
  output logic              due_o,
  output logic [TIME_W-1:0] next_o
);

  // A due slot reloads with period minus one, otherwise it counts down.
  always_comb begin
    due_o  = (countdown_i == '0);
    next_o = (due_o ? period_i : countdown_i) - TIME_W'(1);
  end

endmodule

FILE: sv/pts_ctrl.sv
// Sequencer of the scheduler: handles creates and walks the slots on a tick.
// Depends on pts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pts_ctrl
  import pts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request side
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  req_e                  in_req_i,
  input  logic [TASK_W-1:0]     in_slot_i,
  input  logic [TIME_W-1:0]     in_period_i,
  input  logic [TIME_W-1:0]     in_delay_i,
  // Slot table
  output logic [SLOT_IDX_W-1:0] rd_idx_o,
  input  tbl_rd_t               rd_i,
  output tbl_wr_t               wr_o,
  // Countdown unit
  input  logic                  dec_due_i,
  input  logic [TIME_W-1:0]     dec_next_i,
  // Output register
  input  logic                  push_ok_i,
  output result_t               push_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [SLOT_IDX_W-1:0] idx_q, idx_d;
  logic                  pend_valid_q, pend_valid_d;
  kind_e                 pend_kind_q, pend_kind_d;
  logic [TASK_W-1:0]     pend_id_q, pend_id_d;
  logic                  in_range;
  logic                  stall;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_range   = ({1'b0, in_slot_i} < NUM_SLOTS_EXT);
  assign rd_idx_o   = (state_q == S_IDLE) ? in_slot_i[SLOT_IDX_W-1:0] : idx_q;

  // A newly found due slot must wait while the previous one cannot be sent.
  assign stall = rd_i.used && dec_due_i && pend_valid_q && !push_ok_i;

  // Next-state and datapath control.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_id_d    = pend_id_q;

    push_o         = '0;
    push_o.kind    = KIND_DUE;
    push_o.task_id = pend_id_q;

    wr_o           = '0;
    wr_o.idx       = rd_idx_o;
    wr_o.period    = in_period_i;
    wr_o.countdown = (state_q == S_IDLE) ? in_delay_i : dec_next_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i == REQ_CREATE) begin
            pend_valid_d = 1'b1;
            pend_id_d    = in_slot_i;
            if (in_range && !rd_i.used) begin
              wr_o.used_we   = 1'b1;
              wr_o.period_we = 1'b1;
              wr_o.cd_we     = 1'b1;
              pend_kind_d    = KIND_ACCEPT;
            end else begin
              pend_kind_d    = KIND_REJECT;
            end
            state_d = S_FLUSH;
          end else begin
            idx_d        = '0;
            pend_valid_d = 1'b0;
            state_d      = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (!stall) begin
          if (rd_i.used) begin
            wr_o.cd_we = 1'b1;
            if (dec_due_i) begin
              // Send the previous due slot; it is known not to be the last.
              push_o.valid = pend_valid_q;
              pend_valid_d = 1'b1;
              pend_kind_d  = KIND_DUE;
              pend_id_d    = TASK_W'(idx_q);
            end
          end
          if (idx_q == LAST_SLOT) begin
            state_d = S_FLUSH;
          end else begin
            idx_d = idx_q + SLOT_IDX_W'(1);
          end
        end
      end

      S_FLUSH: begin
        if (push_ok_i) begin
          push_o.valid   = 1'b1;
          push_o.kind    = pend_valid_q ? pend_kind_q : KIND_IDLE;
          push_o.task_id = pend_valid_q ? pend_id_q : '0;
          push_o.last    = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Walk index and pending result payload.
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pend_kind_q <= pend_kind_d;
    pend_id_q   <= pend_id_d;
  end

  `PTS_ASSERT_IMP(a_push_room, push_o.valid, push_ok_i, "result pushed into a full output register")
  `PTS_ASSERT_IMP(a_mid_walk, push_o.valid && !push_o.last, state_q == S_WALK, "non-final result outside a tick walk")
  `PTS_ASSERT_NXT(a_flush_done, (state_q == S_FLUSH) && push_ok_i, state_q == S_IDLE, "final result did not end the transaction")
  `PTS_ASSERT_IMP(a_create_idle, wr_o.used_we, (state_q == S_IDLE) && in_range, "slot claimed outside a create")

endmodule

FILE: sv/periodic_task_tick_scheduler_top.sv
// Top level of the periodic task tick scheduler.
// Depends on pts_pkg, pts_slot_tbl, pts_dec_unit and pts_ctrl.

// A create request is accepted in the idle state and gives one result, which
// is issued from the flush state. A tick is accepted in the idle state, then
// the shared countdown unit visits the slots in priority order, and the
// final result is issued from the flush state. Either kind of request is held
// up while a result, due or final, waits for room in the output register.
// The block takes no new request until the final result of the current one
// sits in the output register; that register lets the next request in while
// the result waits to be taken.
module periodic_task_tick_scheduler_top
  import pts_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [3:0] task_slot, [19:4] period, [35:20] first_delay, [39:36] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                   s_axis_tuser,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [3:0] task_id, [7:4] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  logic [SLOT_IDX_W-1:0] rd_idx;
  tbl_rd_t               rd;
  tbl_wr_t               wr;
  logic                  dec_due;
  logic [TIME_W-1:0]     dec_next;
  logic                  push_ok;
  result_t               push;
  req_e                  in_req;

  logic                  out_valid_q;
  kind_e                 out_kind_q;
  logic [TASK_W-1:0]     out_id_q;
  logic                  out_last_q;

  assign in_req = req_e'(s_axis_tuser);

  pts_slot_tbl u_tbl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd),
    .wr_i     (wr)
  );

  pts_dec_unit u_dec (
    .countdown_i (rd.countdown),
    .period_i    (rd.period),
    .due_o       (dec_due),
    .next_o      (dec_next)
  );

  pts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (in_req),
    .in_slot_i   (s_axis_tdata[3:0]),
    .in_period_i (s_axis_tdata[19:4]),
    .in_delay_i  (s_axis_tdata[35:20]),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd),
    .wr_o        (wr),
    .dec_due_i   (dec_due),
    .dec_next_i  (dec_next),
    .push_ok_i   (push_ok),
    .push_o      (push)
  );

  // The output register has room when empty or when its content leaves now.
  assign push_ok = !out_valid_q || m_axis_tready;

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_kind_q <= push.kind;
      out_id_q   <= push.task_id;
      out_last_q <= push.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_id_q);
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: bench/pts_dispatch_checker.sv
// Checker for the periodic task tick scheduler: watches both streams, predicts
// the results of each accepted request and compares them as they come out.
// Depends on pts_pkg.
`timescale 1ns / 100ps

module pts_dispatch_checker
  import pts_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [1:0]             m_axis_tuser,
  input  logic                   m_axis_tlast,
  output int                     err_cnt_o,
  output int                     pending_o
);

  // One expected result transaction.
  typedef struct packed {
    kind_e             kind;
    logic [TASK_W-1:0] task_id;
    logic              last;
  } dispatch_t;

  // Shadow copy of the task table.
  logic [TIME_W-1:0] period_tbl    [NUM_SLOTS];
  logic [TIME_W-1:0] countdown_tbl [NUM_SLOTS];
  logic              used_tbl      [NUM_SLOTS];

  dispatch_t expected_q [$];
  int        err_cnt = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] dispatch mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // Apply one request to the shadow table and queue the results it causes.
  task automatic schedule_request(input req_e req, input logic [TASK_W-1:0] slot,
                                  input logic [TIME_W-1:0] per,
                                  input logic [TIME_W-1:0] dly);
    int last_due;
    last_due = -1;
    if (req == REQ_CREATE) begin
      if (slot < NUM_SLOTS && !used_tbl[slot]) begin
        period_tbl[slot]    = per;
        countdown_tbl[slot] = dly;
        used_tbl[slot]      = 1'b1;
        expected_q.push_back('{kind: KIND_ACCEPT, task_id: slot, last: 1'b1});
      end else begin
        expected_q.push_back('{kind: KIND_REJECT, task_id: slot, last: 1'b1});
      end
    end else begin
      // Find the final due slot first so that it alone carries the last mark.
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (used_tbl[i] && countdown_tbl[i] == '0) last_due = i;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (used_tbl[i]) begin
          if (countdown_tbl[i] == '0) begin
            expected_q.push_back('{kind: KIND_DUE, task_id: TASK_W'(i),
                                   last: (i == last_due)});
            countdown_tbl[i] = period_tbl[i] - 1'b1;
          end else begin
            countdown_tbl[i] = countdown_tbl[i] - 1'b1;
          end
        end
      end
      if (last_due < 0) begin
        expected_q.push_back('{kind: KIND_IDLE, task_id: '0, last: 1'b1});
      end
    end
  endtask

  // Predict on each request transaction, then check each result transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) used_tbl[i] = 1'b0;
      expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        schedule_request(req_e'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[19:4],
                         s_axis_tdata[35:20]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d task %0d",
                                    m_axis_tuser, m_axis_tdata[3:0]));
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tuser !== want.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", m_axis_tuser, want.kind));
          end
          if (m_axis_tdata[3:0] !== want.task_id) begin
            report_mismatch($sformatf("task_id %0d, expected %0d",
                                      m_axis_tdata[3:0], want.task_id));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", m_axis_tlast, want.last));
          end
        end
      end
    end
    err_cnt_o <= err_cnt;
    pending_o <= expected_q.size();
  end

endmodule

FILE: bench/periodic_task_tick_scheduler_top_tb.sv
// Testbench top for the periodic task tick scheduler: drives directed and
// random requests with random idling and gives the verdict.
// Depends on pts_pkg, periodic_task_tick_scheduler_top and pts_dispatch_checker.
`timescale 1ns / 100ps

module periodic_task_tick_scheduler_top_tb;
  import pts_pkg::*;

  localparam int RANDOM_REQS = 215;
  localparam int LIMIT_NS    = 2_000_000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  int                     err_cnt;
  int                     pending;

  // Percentages of cycles in which each side holds off.
  int send_idle_pct = 22;
  int recv_idle_pct = 57;

  periodic_task_tick_scheduler_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  pts_dispatch_checker dispatch_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending)
  );

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: ready toggles at random at each falling edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #LIMIT_NS;
    $display("periodic_task_tick_scheduler_top_tb: errors");
    $finish;
  end

  // Present one request after a random hold-off and wait for its transaction.
  task automatic issue_request(input req_e req, input logic [TASK_W-1:0] slot,
                               input logic [TIME_W-1:0] per,
                               input logic [TIME_W-1:0] dly);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = req;
    s_axis_tdata  = {4'b0000, dly, per, slot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin
    logic [TASK_W-1:0] slot;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] dly;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = REQ_CREATE;
    s_axis_tdata  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, out-of-range and reused slots, zero and full
    // periods, ticks with one, several or no task due. Slots 1, 2, 4 and 6
    // stay free for the random part.
    issue_request(REQ_TICK,   4'hF,  16'hFFFF, 16'hFFFF);
    issue_request(REQ_CREATE, 4'hF,  16'hFFFF, 16'hFFFF);
    issue_request(REQ_CREATE, 4'h8,  16'h0000, 16'h0000);
    issue_request(REQ_CREATE, 4'h0,  16'h0000, 16'h0000);
    issue_request(REQ_CREATE, 4'h0,  16'h0005, 16'h0005);
    issue_request(REQ_CREATE, 4'h7,  16'hFFFF, 16'hFFFF);
    issue_request(REQ_CREATE, 4'h3,  16'h0002, 16'h0000);
    issue_request(REQ_TICK,   4'h0,  16'h0000, 16'h0000);
    issue_request(REQ_TICK,   4'h0,  16'h0000, 16'h0000);
    issue_request(REQ_TICK,   4'h0,  16'h0000, 16'h0000);
    issue_request(REQ_CREATE, 4'h5,  16'h0001, 16'h0001);
    issue_request(REQ_CREATE, 4'h7,  16'h0001, 16'h0000);
    issue_request(REQ_TICK,   4'h0,  16'h0000, 16'h0000);
    issue_request(REQ_TICK,   4'h0,  16'h0000, 16'h0000);
    issue_request(REQ_TICK,   4'h0,  16'h0000, 16'h0000);

    // Random: mostly ticks, with creates that favor short periods so that
    // tasks fall due often and several at once.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 22;
      end else if (n == 2 * RANDOM_REQS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(99) < 20) begin
        slot = ($urandom_range(3) == 0) ? TASK_W'($urandom_range(15))
                                        : TASK_W'($urandom_range(NUM_SLOTS - 1));
        per  = ($urandom_range(7) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(2, 9));
        dly  = ($urandom_range(7) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(6));
        issue_request(REQ_CREATE, slot, per, dly);
      end else begin
        issue_request(REQ_TICK, TASK_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    // Drain the outstanding results, then watch for stray ones.
    while (pending != 0) @(posedge clk_i);
    repeat (2 * (NUM_SLOTS + 2)) @(posedge clk_i);

    if (err_cnt == 0 && pending == 0) begin
      $display("periodic_task_tick_scheduler_top_tb: clean");
    end else begin
      $display("periodic_task_tick_scheduler_top_tb: errors");
    end
    $finish;
  end

endmodule
